// ===== hdl/tcrb_pkg.sv =====
`default_nettype none

package tcrb_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_SPACES  = 2;
  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

  localparam int ADDR_W    = $clog2(STORE_CELLS);
  localparam int FILL_W    = $clog2(STORE_CELLS + 1);
  localparam int CHAR_W    = 8;
  localparam int COLS_W    = 8;
  localparam int ROWS_W    = 7;
  localparam int BS_W      = 5;
  localparam int ROWIDX_W  = 6;
  localparam int COLIDX_W  = 7;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int MOD_CNT_W = $clog2(FILL_W);
  localparam int TAB_CNT_W = $clog2(TAB_SPACES + 1);

  localparam logic [COLS_W-1:0] COLS_RESET = 8'd79;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd30;
  localparam logic [BS_W-1:0]   BS_RESET   = 5'd8;

  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL        = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CH_CTRL_MAX  = 8'd27;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS   = 2'd0,
    REG_ROWS      = 2'd1,
    REG_BACKSPACE = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    K_NOP,
    K_PRINT,
    K_TAB,
    K_NL,
    K_BS,
    K_READ,
    K_CLEAR
  } kind_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_TOTAL,
    OP_START,
    OP_PR_SETTLE,
    OP_NL_SETUP,
    OP_RD_CHECK,
    OP_BASE,
    OP_MOD_START,
    OP_MOD_WAIT,
    OP_PUT,
    OP_NL_WRITE,
    OP_NL_SETTLE,
    OP_RD_MEM,
    OP_BS,
    OP_CLEAR,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_PR_SETTLE,
    ST_NL_CHECK,
    ST_RD_CHECK,
    ST_BASE,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_PUT,
    ST_NL_WRITE,
    ST_NL_SETTLE,
    ST_RD_MEM,
    ST_BS,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  rd_hit;
    logic  nl_write;
    logic  nl_last;
    logic  mod_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tcrb_if.sv =====
`default_nettype none

interface tcrb_in_if import tcrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAR_W-1:0]   char_code;
  logic [ROWIDX_W-1:0] row;
  logic [COLIDX_W-1:0] column;

  modport source (output valid, command, char_code, row, column, input ready);
  modport sink   (input valid, command, char_code, row, column, output ready);
endinterface

interface tcrb_out_if import tcrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic                cell_filled;
  logic                cell_drawable;
  logic [FILL_W-1:0]   fill_count;
  logic [ROWIDX_W-1:0] cursor_row;
  logic [ROWIDX_W-1:0] top_row;

  modport source (output valid, cell_char, cell_filled, cell_drawable, fill_count,
                  cursor_row, top_row, input ready);
  modport sink   (input valid, cell_char, cell_filled, cell_drawable, fill_count,
                  cursor_row, top_row, output ready);
endinterface

interface tcrb_cfg_if import tcrb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcrb_mod.sv =====
`default_nettype none

module tcrb_mod import tcrb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [FILL_W-1:0] dividend_i,
  input  wire logic [FILL_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [FILL_W-1:0]    num_q, num_d;
  logic [FILL_W-1:0]    rem_q, rem_d;
  logic [FILL_W-1:0]    div_q, div_d;
  logic [FILL_W:0]      trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, num_q[FILL_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = MOD_CNT_W'(FILL_W - 1);
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = FILL_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[FILL_W-1:0];
      end
      num_d = {num_q[FILL_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/tcrb_dp.sv =====
`default_nettype none

module tcrb_dp import tcrb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [CHAR_W-1:0]    char_code_i,
  input  wire logic [ROWIDX_W-1:0]  row_i,
  input  wire logic [COLIDX_W-1:0]  column_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  output logic [CHAR_W-1:0]         cell_char_o,
  output logic                      cell_filled_o,
  output logic                      cell_drawable_o,
  output logic [FILL_W-1:0]         fill_count_o,
  output logic [ROWIDX_W-1:0]       cursor_row_o,
  output logic [ROWIDX_W-1:0]       top_row_o
);

  // configuration
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [BS_W-1:0]   bs_q;
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;

  // console state
  logic [FILL_W-1:0]   filled_q, filled_d;
  logic [ROWIDX_W-1:0] cursor_q, cursor_d;
  logic [ROWIDX_W-1:0] top_q, top_d;

  // item and work registers
  cmd_e                command_q;
  logic [CHAR_W-1:0]   char_code_q;
  logic [ROWIDX_W-1:0] row_q;
  logic [COLIDX_W-1:0] column_q;
  logic [FILL_W-1:0]   total_q;
  logic [FILL_W-1:0]   start_q;
  logic [FILL_W-1:0]   base_q;
  logic [ADDR_W-1:0]   phys_q;
  logic [COLS_W-1:0]   count_q;
  logic [CHAR_W-1:0]   wval_q;
  logic                hit_q;
  logic [CHAR_W-1:0]   rdata_q;

  // result registers
  logic [CHAR_W-1:0]   res_char_q;
  logic                res_filled_q;
  logic                res_draw_q;
  logic [FILL_W-1:0]   res_fill_q;
  logic [ROWIDX_W-1:0] res_cursor_q;
  logic [ROWIDX_W-1:0] res_top_q;

  logic [CHAR_W-1:0]   store_q [STORE_CELLS];

  kind_e               kind;
  logic [CHAR_W-1:0]   ch;
  logic [ROWS_W-1:0]   mul_b;
  logic [FILL_W:0]     prod;
  logic [FILL_W-1:0]   cell_idx;
  logic [FILL_W-1:0]   nl_x;
  logic                pr_inc;
  logic [ROWS_W-1:0]   rowv;
  logic [ROWS_W-1:0]   top_inc;
  logic [ROWIDX_W-1:0] set_cursor;
  logic [ROWIDX_W-1:0] set_top;
  logic [FILL_W-1:0]   set_fill;
  logic [FILL_W-1:0]   fill_inc;
  logic                not_full;
  logic [ADDR_W-1:0]   phys_next;
  logic                mem_we;
  logic [CHAR_W-1:0]   mem_wdata;
  logic                mod_start;
  logic [FILL_W-1:0]   mod_dividend;
  logic                mod_done;
  logic [ADDR_W-1:0]   mod_rem;

  always_comb begin
    cols_eff = cols_q;
    if (cols_q == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cols_q > COLS_W'(MAX_COLUMNS)) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end
    rows_eff = rows_q;
    if (rows_q == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (rows_q > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end
  end

  // byte classification
  always_comb begin
    ch   = (char_code_q == CH_CR) ? CH_NL : char_code_q;
    kind = K_NOP;
    unique case (command_q)
      CMD_PUT: begin
        if (ch == {3'b000, bs_q}) begin
          kind = K_BS;
        end else if (ch == CH_TAB) begin
          kind = K_TAB;
        end else if (ch == CH_NL) begin
          kind = K_NL;
        end else if (ch > CH_CTRL_MAX && ch <= CH_PRINT_MAX) begin
          kind = K_PRINT;
        end
      end
      CMD_READ:  kind = K_READ;
      CMD_CLEAR: kind = K_CLEAR;
      CMD_NOP:   kind = K_NOP;
    endcase
  end

  // shared multiplier: columns times a row count
  always_comb begin
    case (cmd_i.op)
      OP_TOTAL: mul_b = rows_eff;
      OP_START: mul_b = (kind == K_READ) ? {1'b0, row_q} : {1'b0, cursor_q};
      OP_BASE:  mul_b = {1'b0, top_q};
      default:  mul_b = '0;
    endcase
  end
  assign prod = (FILL_W + 1)'(cols_eff) * (FILL_W + 1)'(mul_b);

  assign cell_idx = start_q + FILL_W'(column_q);
  assign nl_x     = filled_q - start_q;

  // cursor row settle with scroll
  assign pr_inc  = ({1'b0, filled_q} + (FILL_W + 1)'(1)) ==
                   ({1'b0, start_q} + (FILL_W + 1)'(cols_eff));
  assign rowv    = (cmd_i.op == OP_NL_SETTLE) ? ({1'b0, cursor_q} + ROWS_W'(1))
                                              : ({1'b0, cursor_q} + ROWS_W'(pr_inc));
  assign top_inc = {1'b0, top_q} + ROWS_W'(1);

  always_comb begin
    set_cursor = rowv[ROWIDX_W-1:0];
    set_top    = top_q;
    set_fill   = filled_q;
    if (rowv >= rows_eff) begin
      set_cursor = ROWIDX_W'(rowv - ROWS_W'(1));
      set_top    = (top_inc >= rows_eff) ? '0 : top_inc[ROWIDX_W-1:0];
      set_fill   = (filled_q >= FILL_W'(cols_eff)) ? filled_q - FILL_W'(cols_eff) : '0;
    end
  end

  assign not_full  = filled_q < FILL_W'(STORE_CELLS);
  assign fill_inc  = not_full ? filled_q + FILL_W'(1) : filled_q;
  assign phys_next = (({1'b0, phys_q} + FILL_W'(1)) == total_q) ? '0
                                                                 : phys_q + ADDR_W'(1);

  always_comb begin
    filled_d = filled_q;
    cursor_d = cursor_q;
    top_d    = top_q;
    case (cmd_i.op)
      OP_PR_SETTLE, OP_NL_SETTLE: begin
        filled_d = set_fill;
        cursor_d = set_cursor;
        top_d    = set_top;
      end
      OP_PUT, OP_NL_WRITE: filled_d = fill_inc;
      OP_BS: begin
        if (filled_q != '0) begin
          filled_d = filled_q - FILL_W'(1);
        end
      end
      OP_CLEAR: begin
        filled_d = '0;
        cursor_d = '0;
        top_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= COLS_RESET;
      rows_q   <= ROWS_RESET;
      bs_q     <= BS_RESET;
      filled_q <= '0;
      cursor_q <= '0;
      top_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_COLUMNS:   cols_q <= cfg_data_i[COLS_W-1:0];
          REG_ROWS:      rows_q <= cfg_data_i[ROWS_W-1:0];
          REG_BACKSPACE: bs_q   <= cfg_data_i[BS_W-1:0];
          default: ;
        endcase
      end
      filled_q <= filled_d;
      cursor_q <= cursor_d;
      top_q    <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        command_q   <= cmd_e'(command_i);
        char_code_q <= char_code_i;
        row_q       <= row_i;
        column_q    <= column_i;
        hit_q       <= 1'b0;
      end
      OP_TOTAL: total_q <= prod[FILL_W-1:0];
      OP_START: start_q <= prod[FILL_W-1:0];
      OP_BASE:  base_q  <= prod[FILL_W-1:0];
      OP_RD_CHECK: hit_q <= stat_o.rd_hit;
      OP_NL_SETUP: begin
        count_q <= cols_eff - nl_x[COLS_W-1:0];
        wval_q  <= CH_NL;
      end
      OP_MOD_WAIT: begin
        if (mod_done) begin
          phys_q <= mod_rem;
        end
      end
      OP_NL_WRITE: begin
        wval_q  <= '0;
        count_q <= count_q - COLS_W'(1);
        if (not_full) begin
          phys_q <= phys_next;
        end
      end
      OP_RESULT: begin
        res_char_q   <= hit_q ? rdata_q : '0;
        res_filled_q <= hit_q;
        res_draw_q   <= hit_q && rdata_q != '0 && rdata_q != CH_NL;
        res_fill_q   <= filled_q;
        res_cursor_q <= cursor_q;
        res_top_q    <= top_q;
      end
      default: ;
    endcase
  end

  // cell store
  assign mem_we    = (cmd_i.op == OP_PUT) || (cmd_i.op == OP_NL_WRITE);
  assign mem_wdata = (cmd_i.op == OP_PUT) ? ((kind == K_TAB) ? CH_SPACE : char_code_q)
                                          : wval_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[phys_q] <= mem_wdata;
    end
    if (cmd_i.op == OP_RD_MEM) begin
      rdata_q <= store_q[phys_q];
    end
  end

  // physical index = (cell + columns * top row) mod grid size
  assign mod_start    = cmd_i.op == OP_MOD_START;
  assign mod_dividend = ((kind == K_READ) ? cell_idx : filled_q) + base_q;

  tcrb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    stat_o.kind     = kind;
    stat_o.rd_hit   = ({1'b0, column_q} < cols_eff) && ({1'b0, row_q} < rows_eff) &&
                      (cell_idx < filled_q);
    stat_o.nl_write = (filled_q >= start_q) && (nl_x < FILL_W'(cols_eff));
    stat_o.nl_last  = count_q == COLS_W'(1);
    stat_o.mod_done = mod_done;
  end

  assign cell_char_o     = res_char_q;
  assign cell_filled_o   = res_filled_q;
  assign cell_drawable_o = res_draw_q;
  assign fill_count_o    = res_fill_q;
  assign cursor_row_o    = res_cursor_q;
  assign top_row_o       = res_top_q;

endmodule

`default_nettype wire

// ===== hdl/tcrb_ctrl.sv =====
`default_nettype none

module tcrb_ctrl import tcrb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [TAB_CNT_W-1:0] tab_cnt_q, tab_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tab_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      tab_cnt_q   <= tab_cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tab_cnt_d   = tab_cnt_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op  = OP_LOAD;
          tab_cnt_d = '0;
          state_d   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.op = OP_TOTAL;
        unique case (stat_i.kind)
          K_BS:    state_d = ST_BS;
          K_CLEAR: state_d = ST_CLEAR;
          K_NOP:   state_d = ST_FINISH;
          K_PRINT, K_TAB, K_NL, K_READ: state_d = ST_START;
        endcase
      end
      ST_START: begin
        cmd_o.op = OP_START;
        if (stat_i.kind == K_NL) begin
          state_d = ST_NL_CHECK;
        end else if (stat_i.kind == K_READ) begin
          state_d = ST_RD_CHECK;
        end else begin
          state_d = ST_PR_SETTLE;
        end
      end
      ST_PR_SETTLE: begin
        cmd_o.op = OP_PR_SETTLE;
        state_d  = ST_BASE;
      end
      ST_NL_CHECK: begin
        cmd_o.op = OP_NL_SETUP;
        state_d  = stat_i.nl_write ? ST_BASE : ST_NL_SETTLE;
      end
      ST_RD_CHECK: begin
        cmd_o.op = OP_RD_CHECK;
        state_d  = stat_i.rd_hit ? ST_BASE : ST_FINISH;
      end
      ST_BASE: begin
        cmd_o.op = OP_BASE;
        state_d  = ST_MOD_START;
      end
      ST_MOD_START: begin
        cmd_o.op = OP_MOD_START;
        state_d  = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        cmd_o.op = OP_MOD_WAIT;
        if (stat_i.mod_done) begin
          if (stat_i.kind == K_READ) begin
            state_d = ST_RD_MEM;
          end else if (stat_i.kind == K_NL) begin
            state_d = ST_NL_WRITE;
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_PUT: begin
        cmd_o.op = OP_PUT;
        if (stat_i.kind == K_TAB && tab_cnt_q != TAB_CNT_W'(TAB_SPACES - 1)) begin
          tab_cnt_d = tab_cnt_q + TAB_CNT_W'(1);
          state_d   = ST_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_NL_WRITE: begin
        cmd_o.op = OP_NL_WRITE;
        if (stat_i.nl_last) begin
          state_d = ST_NL_SETTLE;
        end
      end
      ST_NL_SETTLE: begin
        cmd_o.op = OP_NL_SETTLE;
        state_d  = ST_FINISH;
      end
      ST_RD_MEM: begin
        cmd_o.op = OP_RD_MEM;
        state_d  = ST_FINISH;
      end
      ST_BS: begin
        cmd_o.op = OP_BS;
        state_d  = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/text_console_ring_buffer.sv =====
// channel  dir  handshake     payload
// cfg_i    in   valid/ready   index, data (ready always high)
// in_i     in   valid/ready   command, char_code, row, column
// out_o    out  valid/ready   cell_char, cell_filled, cell_drawable, fill_count,
//                             cursor_row, top_row
//
// one transaction at a time; the 14-step remainder unit finds the cell for each
// read hit, printable byte, tab space or newline; a newline pads its row
// with one cell write per cycle; backspace and clear skip the remainder unit
// reset clears console state and configuration registers; the cell store is not cleared
// a waiting result does not block the next input transaction; a new result
// waits in the finish state until the output register is free
`default_nettype none

module text_console_ring_buffer import tcrb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcrb_cfg_if.sink   cfg_i,
  tcrb_in_if.sink    in_i,
  tcrb_out_if.source out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_i.ready = 1'b1;

  tcrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tcrb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid && cfg_i.ready),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .command_i       (in_i.command),
    .char_code_i     (in_i.char_code),
    .row_i           (in_i.row),
    .column_i        (in_i.column),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .cell_char_o     (out_o.cell_char),
    .cell_filled_o   (out_o.cell_filled),
    .cell_drawable_o (out_o.cell_drawable),
    .fill_count_o    (out_o.fill_count),
    .cursor_row_o    (out_o.cursor_row),
    .top_row_o       (out_o.top_row)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a transaction is in progress");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(dp_cmd.op == OP_RESULT))
    else $error("result valid without a result load");

  a_mod_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.mod_done |-> dp_cmd.op == OP_MOD_WAIT)
    else $error("remainder done outside the wait state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == OP_RESULT) |=> out_o.fill_count <= FILL_W'(STORE_CELLS))
    else $error("fill count beyond store size");

endmodule

`default_nettype wire
